FILE: hdl/pwmr_pkg.sv
// Shared types and constants for the pulse-width median ranger.
package pwmr_pkg;

  // Pulse width in timer ticks: 16-bit stamp difference plus 4 overflow bits
  localparam int WIDTH_W = 20;
  localparam int STAMP_W = 16;
  localparam int OVF_W   = 4;
  localparam int CFG_W   = 6;

  // Sum of the two middle widths, and the divide-by-three reciprocal
  localparam int NUM_W      = WIDTH_W + 1;
  localparam int DIV3_W     = 22;
  localparam int PROD_W     = NUM_W + DIV3_W;
  localparam int DIV3_SHIFT = 23;
  localparam logic [DIV3_W-1:0] DIV3_MULT = 22'd2796203;  // ceil(2^23 / 3)

  // 30 mm calibration offset: threshold on the sum and amount in 1/16 mm
  localparam logic [NUM_W-1:0]   OFFSET_LIMIT = 21'd1440;
  localparam logic [WIDTH_W-1:0] OFFSET_D16   = 20'd480;

  typedef logic [WIDTH_W-1:0] width_t;

  // Per-cell control: insert or drain strobe, plus where the cell sits
  typedef struct packed {
    logic ins;    // insert the pending width this cycle
    logic drain;  // shift the whole row one place toward cell 0
    logic occ;    // cell holds a stored width
    logic tail;   // cell is the first free slot
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_DRAIN,
    ST_SUM,
    ST_MUL,
    ST_OUT
  } state_t;

endpackage

FILE: hdl/pwmr_cell.sv
// One slot of the sorted width row: insertion shift and drain shift.
module pwmr_cell (
  input  logic               clk,
  input  pwmr_pkg::cell_ctl_t ctl,
  input  pwmr_pkg::width_t   new_w,
  input  pwmr_pkg::width_t   left_val,
  input  logic               left_gt,
  input  pwmr_pkg::width_t   right_val,
  output pwmr_pkg::width_t   val,
  output logic               gt
);

  pwmr_pkg::width_t val_r;
  pwmr_pkg::width_t val_nxt;
  logic             take;

  // This cell's stored width is above the one being inserted
  assign gt = ctl.occ && (val_r > new_w);

  // Take a value when the insert point is here or to the left of us
  assign take = (ctl.occ && gt) || ctl.tail;

  always_comb begin
    val_nxt = val_r;
    if (ctl.drain) begin
      val_nxt = right_val;
    end else if (ctl.ins && take) begin
      val_nxt = left_gt ? left_val : new_w;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

FILE: hdl/pulse_width_median_ranger.sv
// Top level: pulse width capture, sorted cell row and median distance output.
//
//  channel | ports                                          | handshake
//  --------+------------------------------------------------+-----------------
//  input   | in_rise_time, in_fall_time, in_overflows       | in_valid/in_ready
//  result  | out_distance                                   | out_valid/out_ready
//  config  | cfg_wr_data (sample_count)                     | cfg_wr_en
//
// An item that does not close a batch is accepted, then takes one
// insertion step across the cell row. An item that closes a batch of n
// widths is accepted and inserted; then the row drains toward cell 0 until
// the middle width sits there, then sum, multiply, offset.
// rst_n is synchronous: it empties the row and sets sample_count to 1.
// A result waits in the output register; a new one is held back only while
// that register is still full and out_ready is low.
module pulse_width_median_ranger #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pwmr_pkg::STAMP_W-1:0]     in_rise_time,
  input  logic [pwmr_pkg::STAMP_W-1:0]     in_fall_time,
  input  logic [pwmr_pkg::OVF_W-1:0]       in_overflows,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pwmr_pkg::WIDTH_W-1:0]     out_distance,
  input  logic                             cfg_wr_en,
  input  logic [pwmr_pkg::CFG_W-1:0]       cfg_wr_data
);

  localparam int FILL_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES + 1) : 1;
  localparam int CMP_W  = 8;

  pwmr_pkg::state_t state_r, state_nxt;
  logic [FILL_W-1:0]          filled_r, filled_nxt;
  logic [FILL_W-1:0]          cnt_r, cnt_nxt;
  logic                       odd_r, odd_nxt;
  logic [pwmr_pkg::CFG_W-1:0] cfg_r;
  logic                       out_valid_r, out_valid_nxt;

  pwmr_pkg::width_t                w_r;
  pwmr_pkg::width_t                w_calc;
  logic [pwmr_pkg::NUM_W-1:0]      num_r;
  logic [pwmr_pkg::PROD_W-1:0]     prod;
  pwmr_pkg::width_t                q_r;
  logic                            big_r;
  pwmr_pkg::width_t                out_distance_r;

  logic ins;
  logic drain;
  logic batch_done;
  logic load_out;
  logic [CMP_W-1:0] count_after;

  pwmr_pkg::width_t cell_val [MAX_SAMPLES+1];
  logic             cell_gt  [MAX_SAMPLES];

  // Pulse width: modular stamp difference, one overflow less on wrap
  logic [pwmr_pkg::STAMP_W-1:0] stamp_diff;
  logic [pwmr_pkg::OVF_W-1:0]   ovf_adj;
  always_comb begin
    stamp_diff = in_fall_time - in_rise_time;
    ovf_adj    = in_overflows;
    if ((in_fall_time < in_rise_time) && (in_overflows != '0)) begin
      ovf_adj = in_overflows - pwmr_pkg::OVF_W'(1);
    end
    w_calc = {ovf_adj, stamp_diff};
  end

  // Batch closes once the new count reaches min(max(count,1), MAX_SAMPLES)
  assign count_after = CMP_W'(filled_r) + CMP_W'(1);
  assign batch_done  = (count_after >= CMP_W'(MAX_SAMPLES)) ||
                       (count_after >= CMP_W'(cfg_r));

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    filled_nxt    = filled_r;
    cnt_nxt       = cnt_r;
    odd_nxt       = odd_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    ins           = 1'b0;
    drain         = 1'b0;
    load_out      = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      pwmr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = pwmr_pkg::ST_INS;
        end
      end
      pwmr_pkg::ST_INS: begin
        ins = 1'b1;
        if (batch_done) begin
          filled_nxt = '0;
          cnt_nxt    = filled_r >> 1;
          odd_nxt    = ~filled_r[0];
          state_nxt  = pwmr_pkg::ST_DRAIN;
        end else begin
          filled_nxt = filled_r + FILL_W'(1);
          state_nxt  = pwmr_pkg::ST_IDLE;
        end
      end
      pwmr_pkg::ST_DRAIN: begin
        if (cnt_r == '0) begin
          state_nxt = pwmr_pkg::ST_SUM;
        end else begin
          drain   = 1'b1;
          cnt_nxt = cnt_r - FILL_W'(1);
        end
      end
      pwmr_pkg::ST_SUM: begin
        state_nxt = pwmr_pkg::ST_MUL;
      end
      pwmr_pkg::ST_MUL: begin
        state_nxt = pwmr_pkg::ST_OUT;
      end
      pwmr_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pwmr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pwmr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pwmr_pkg::ST_IDLE;
      filled_r    <= '0;
      cnt_r       <= '0;
      odd_r       <= 1'b0;
      cfg_r       <= pwmr_pkg::CFG_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filled_r    <= filled_nxt;
      cnt_r       <= cnt_nxt;
      odd_r       <= odd_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
  end

  // Median arithmetic: sum, divide by three via reciprocal, offset
  assign prod = pwmr_pkg::PROD_W'(num_r) * pwmr_pkg::PROD_W'(pwmr_pkg::DIV3_MULT);

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      w_r <= w_calc;
    end
    if (state_r == pwmr_pkg::ST_SUM) begin
      num_r <= odd_r ? {cell_val[0], 1'b0}
                     : pwmr_pkg::NUM_W'(cell_val[0]) + pwmr_pkg::NUM_W'(cell_val[1]);
    end
    if (state_r == pwmr_pkg::ST_MUL) begin
      q_r   <= pwmr_pkg::WIDTH_W'(prod >> pwmr_pkg::DIV3_SHIFT);
      big_r <= num_r > pwmr_pkg::OFFSET_LIMIT;
    end
    if (load_out) begin
      out_distance_r <= big_r ? (q_r - pwmr_pkg::OFFSET_D16) : q_r;
    end
  end

  // Row of sorted cells; the slot past the end feeds zeros into the drain
  assign cell_val[MAX_SAMPLES] = '0;

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    pwmr_pkg::cell_ctl_t ctl;
    pwmr_pkg::width_t    left_val;
    logic                left_gt;

    assign ctl.ins   = ins;
    assign ctl.drain = drain;
    assign ctl.occ   = FILL_W'(i) < filled_r;
    assign ctl.tail  = FILL_W'(i) == filled_r;

    if (i == 0) begin : g_head
      assign left_val = w_r;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_val = cell_val[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    pwmr_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_w     (w_r),
      .left_val  (left_val),
      .left_gt   (left_gt),
      .right_val (cell_val[i+1]),
      .val       (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;

endmodule

FILE: bench/tb_pulse_width_median_ranger.sv
// Testbench for the pulse-width median ranger: pulses in, median distances checked per batch.
module tb_pulse_width_median_ranger;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SAMPLES   = 32;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PULSES = 440;

  typedef struct packed {
    logic [pwmr_pkg::STAMP_W-1:0] rise;
    logic [pwmr_pkg::STAMP_W-1:0] fall;
    logic [pwmr_pkg::OVF_W-1:0]   ovf;
  } pulse_t;

  // Tracks the sorted widths of the open batch and the distances still owed
  class median_tracker;
    int unsigned                widths[MAX_SAMPLES];
    int unsigned                fill;
    logic [pwmr_pkg::CFG_W-1:0] sample_count;
    pwmr_pkg::width_t           pending_distances[$];
    int unsigned                mismatches;

    function new();
      fill = 0;
      sample_count = pwmr_pkg::CFG_W'(1);
      mismatches = 0;
    endfunction

    function void set_count(logic [pwmr_pkg::CFG_W-1:0] value);
      sample_count = value;
    endfunction

    function void note_pulse(pulse_t p);
      int unsigned                  batch;
      int unsigned                  ovf_left;
      int unsigned                  w;
      int unsigned                  pos;
      int unsigned                  num;
      int unsigned                  d16;
      logic [pwmr_pkg::STAMP_W-1:0] span;
      // zero acts as one, anything past the store size as the store size
      batch = (sample_count == 0) ? 1 : sample_count;
      if (batch > MAX_SAMPLES) batch = MAX_SAMPLES;
      if (fill >= MAX_SAMPLES) fill = MAX_SAMPLES - 1;

      // width in ticks; a fall stamp below the rise stamp used up one overflow
      span = p.fall - p.rise;
      ovf_left = p.ovf;
      if (p.fall < p.rise && ovf_left > 0) ovf_left--;
      w = (span + (ovf_left << pwmr_pkg::STAMP_W)) & ((1 << pwmr_pkg::WIDTH_W) - 1);

      // sorted insertion
      pos = fill;
      while (pos > 0 && widths[pos-1] > w) begin
        widths[pos] = widths[pos-1];
        pos--;
      end
      widths[pos] = w;
      fill++;

      // batch complete: median distance in 1/16 mm, less the 30 mm offset past the threshold
      if (fill >= batch) begin
        if (fill % 2 == 1) num = 2 * widths[fill/2];
        else num = widths[fill/2-1] + widths[fill/2];
        d16 = num / 3;
        if (num > pwmr_pkg::OFFSET_LIMIT) d16 -= pwmr_pkg::OFFSET_D16;
        pending_distances.push_back(pwmr_pkg::width_t'(d16));
        fill = 0;
      end
    endfunction

    function void check_distance(pwmr_pkg::width_t got);
      pwmr_pkg::width_t want;
      if (pending_distances.size() == 0) begin
        mismatches++;
        $display("%0t: distance expected none, got %0d", $time, got);
        return;
      end
      want = pending_distances.pop_front();
      if (got !== want) begin
        mismatches++;
        $display("%0t: distance expected %0d, got %0d", $time, want, got);
      end
    endfunction

    function void check_leftovers();
      if (pending_distances.size() != 0) begin
        mismatches++;
        $display("%0t: %0d distances expected, none arrived (next %0d)", $time,
                 pending_distances.size(), pending_distances[0]);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [pwmr_pkg::STAMP_W-1:0]  in_rise_time;
  logic [pwmr_pkg::STAMP_W-1:0]  in_fall_time;
  logic [pwmr_pkg::OVF_W-1:0]    in_overflows;
  logic                          out_valid;
  logic                          out_ready;
  logic [pwmr_pkg::WIDTH_W-1:0]  out_distance;
  logic                          cfg_wr_en;
  logic [pwmr_pkg::CFG_W-1:0]    cfg_wr_data;

  median_tracker tracker = new();
  bit            gaps_on = 1'b1;
  int unsigned   hold_requests = 0;
  int unsigned   cycles = 0;

  pulse_width_median_ranger #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rise_time(in_rise_time),
    .in_fall_time(in_fall_time),
    .in_overflows(in_overflows),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_distance(out_distance),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned holds_seen;
    hold_left = 0;
    holds_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(99) < 6);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_distance(out_distance);
  end

  // Watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_pulse_width_median_ranger: done, errors");
    $finish;
  end

  // Offer one item and hold it until accepted
  task automatic send_pulse(input logic [pwmr_pkg::STAMP_W-1:0] rise,
                            input logic [pwmr_pkg::STAMP_W-1:0] fall,
                            input logic [pwmr_pkg::OVF_W-1:0] ovf);
    pulse_t p;
    p.rise = rise;
    p.fall = fall;
    p.ovf = ovf;
    if (gaps_on && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rise_time <= rise;
    in_fall_time <= fall;
    in_overflows <= ovf;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_pulse(p);
  endtask

  // Drain every owed distance, then let a pending insertion finish
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [pwmr_pkg::CFG_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_count(value);
  endtask

  function automatic pulse_t random_pulse(pulse_t last);
    pulse_t      p;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    p.rise = pwmr_pkg::STAMP_W'($urandom);
    p.fall = pwmr_pkg::STAMP_W'($urandom);
    p.ovf = pwmr_pkg::OVF_W'($urandom);
    if (kind >= 4 && kind <= 6) begin
      // widths on either side of the 30 mm offset threshold
      p.fall = p.rise + pwmr_pkg::STAMP_W'($urandom_range(600, 840));
      p.ovf = (p.fall < p.rise) ? pwmr_pkg::OVF_W'(1) : pwmr_pkg::OVF_W'(0);
    end else if (kind >= 7 && kind <= 8) begin
      p.ovf = pwmr_pkg::OVF_W'($urandom_range(0, 2));
    end else if (kind == 9) begin
      // repeated width: equal entries in the sorted store
      p = last;
    end
    return p;
  endfunction

  initial begin
    pulse_t      p;
    pulse_t      last;
    int unsigned sent;
    int unsigned phase;
    int unsigned count_pick;
    int unsigned batch;
    int unsigned n;
    last = '0;
    sent = 0;
    phase = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_rise_time <= '0;
    in_fall_time <= '0;
    in_overflows <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // batch of one: stamp and overflow extremes, wrap, offset threshold
    send_pulse(16'h0000, 16'h0000, 4'h0);
    send_pulse(16'h0000, 16'hFFFF, 4'hF);
    send_pulse(16'hFFFF, 16'h0000, 4'h0);
    send_pulse(16'hFFFF, 16'h0000, 4'hF);
    send_pulse(16'hAAAA, 16'h5555, 4'hA);
    send_pulse(16'h5555, 16'hAAAA, 4'h5);
    send_pulse(16'd100, 16'd819, 4'h0);
    send_pulse(16'd100, 16'd820, 4'h0);
    send_pulse(16'd100, 16'd821, 4'h0);

    // zero count behaves as one
    settle();
    write_count(6'd0);
    send_pulse(16'hFFF0, 16'h0010, 4'h3);
    send_pulse(16'h1234, 16'h0234, 4'h0);

    // even count: mean of the middle pair around the threshold
    settle();
    write_count(6'd2);
    send_pulse(16'd0, 16'd720, 4'h0);
    send_pulse(16'd10, 16'd730, 4'h0);
    send_pulse(16'd0, 16'd720, 4'h0);
    send_pulse(16'd0, 16'd721, 4'h0);

    // count lowered below the widths already gathered
    settle();
    write_count(6'd5);
    send_pulse(16'd0, 16'd300, 4'h0);
    send_pulse(16'd0, 16'd100, 4'h0);
    send_pulse(16'd0, 16'd200, 4'h0);
    settle();
    write_count(6'd2);
    send_pulse(16'd0, 16'd50, 4'h0);

    // output held off while pulses keep coming: input must back up
    settle();
    write_count(6'd1);
    hold_requests++;
    repeat (40) begin
      p = random_pulse(last);
      send_pulse(p.rise, p.fall, p.ovf);
      last = p;
    end

    // random phases, each with its own sample count
    while (sent < RANDOM_PULSES) begin
      case ($urandom_range(0, 9))
        0: count_pick = 0;
        1: count_pick = 1;
        2: count_pick = MAX_SAMPLES;
        3: count_pick = 63;
        4: count_pick = $urandom_range(33, 62);
        default: count_pick = $urandom_range(1, 8);
      endcase
      if (phase == 0) count_pick = MAX_SAMPLES;
      if (phase == 1) count_pick = 63;
      batch = (count_pick == 0) ? 1 : count_pick;
      if (batch > MAX_SAMPLES) batch = MAX_SAMPLES;
      n = batch * $urandom_range(1, 3) + $urandom_range(0, batch - 1);

      settle();
      // one phase in eight runs with no stalls on either side
      gaps_on = (phase % 8 != 3);
      if (!gaps_on && n < 60) n = 60;
      write_count(pwmr_pkg::CFG_W'(count_pick));
      repeat (n) begin
        p = random_pulse(last);
        send_pulse(p.rise, p.fall, p.ovf);
        last = p;
        sent++;
      end
      phase++;
    end

    gaps_on = 1'b1;
    settle();
    tracker.check_leftovers();
    if (tracker.mismatches == 0) begin
      $display("tb_pulse_width_median_ranger: done, clean");
    end else begin
      $display("tb_pulse_width_median_ranger: done, errors");
    end
    $finish;
  end

endmodule
